// File: design/cia_pkg.sv
// Shared types, constants and a helper function of the checked integer ALU.
`timescale 1ns / 1ps
package cia_pkg;

	localparam int DW     = 64;          // operand width
	localparam int HW     = (DW + 1) / 2; // half width for the partial products
	localparam int PW     = 4 * HW;       // padded product width
	localparam int RW     = 64;          // result field width
	localparam int OPW    = 64;          // operand field width on the port
	localparam int FUNC_W = 3;
	localparam int ERR_W  = 2;
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	typedef enum logic [FUNC_W-1:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_MOD = 3'd4,
		OP_AND = 3'd5,
		OP_OR  = 3'd6,
		OP_XOR = 3'd7
	} op_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_OK   = 2'd0,
		ERR_OVF  = 2'd1,
		ERR_ZERO = 2'd2
	} err_t;

	// Classified item as handed from the front end to the execution pipeline.
	typedef struct packed {
		op_t            op;
		logic [DW-1:0]  a;
		logic [DW-1:0]  b;
		logic [DW-1:0]  ma;
		logic [DW-1:0]  mb;
		logic           neg_a;
		logic           neg_b;
		err_t           err;
	} item_t;

	typedef struct packed {
		logic           valid;
		op_t            op;
		err_t           err;
		logic           neg_a;
		logic           neg_b;
		logic [DW-1:0]  res;
		logic [DW-1:0]  rem;
		logic [DW-1:0]  qd;
		logic [DW-1:0]  mb;
	} stage_t;

	// One restoring division step: returns the new remainder above the new
	// dividend/quotient shift word.
	function automatic logic [2*DW-1:0] div_step(input logic [DW-1:0] rem,
		input logic [DW-1:0] qd, input logic [DW-1:0] mb);
		logic [DW:0] t;
		logic [DW:0] d;
		t = {rem, qd[DW-1]};
		d = t - {1'b0, mb};
		if (!d[DW]) begin
			return {d[DW-1:0], qd[DW-2:0], 1'b1};
		end
		return {t[DW-1:0], qd[DW-2:0], 1'b0};
	endfunction

endpackage

// File: design/cia_front.sv
// Front end: accepts operand beats, classifies them and registers the result.
`timescale 1ns / 1ps
module cia_front import cia_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [2*OPW-1:0]     s_tdata,  // left_operand, right_operand
	input  logic [FUNC_W-1:0]    s_tuser,  // func
	output logic                 push,
	output item_t                push_item,
	input  logic                 push_ready
);

	logic  valid_s1;
	item_t item_s1;
	item_t cls;
	logic  min_by_m1;

	always_comb begin
		cls.op    = op_t'(s_tuser);
		cls.a     = s_tdata[DW-1:0];
		cls.b     = s_tdata[OPW+DW-1:OPW];
		cls.neg_a = cls.a[DW-1];
		cls.neg_b = cls.b[DW-1];
		cls.ma    = cls.neg_a ? (DW'(0) - cls.a) : cls.a;
		cls.mb    = cls.neg_b ? (DW'(0) - cls.b) : cls.b;
		min_by_m1 = (cls.a == {1'b1, {(DW-1){1'b0}}}) && (cls.b == {DW{1'b1}});
		cls.err   = ERR_OK;
		if (cls.op == OP_DIV || cls.op == OP_MOD) begin
			if (cls.b == '0) begin
				cls.err = ERR_ZERO;
			end else if (min_by_m1) begin
				cls.err = ERR_OVF;
			end
		end
	end

	assign s_tready  = !valid_s1 || push_ready;
	assign push      = valid_s1;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= cls;
		end
	end

endmodule

// File: design/cia_queue.sv
// Short queue of classified items between the front end and the pipeline.
`timescale 1ns / 1ps
module cia_queue import cia_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  item_t  push_item,
	output logic   push_ready,
	input  logic   pop,
	output item_t  head,
	output logic   head_valid
);

	item_t          mem_q [QDEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QAW:0]   cnt_q;
	logic           do_push;
	logic           do_pop;

	assign push_ready = (cnt_q != (QAW+1)'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_item;
	end

endmodule

// File: design/cia_back.sv
// Execution pipeline: add, sub and logic ops, pipelined multiplier and divider, output register.
`timescale 1ns / 1ps
module cia_back import cia_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  item_t             head,
	input  logic              head_valid,
	output logic              pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [RW-1:0]     m_tdata,  // result_value
	output logic [ERR_W-1:0]  m_tuser   // error_code
);

	stage_t           stg_s [1:DW];
	logic [2*HW-1:0]  pp_s1 [4];
	logic [PW-1:0]    prod_s2;
	logic             out_valid_q;
	logic [RW-1:0]    out_res_q;
	err_t             out_err_q;
	logic             en;

	// The whole pipeline moves as one; a full output register that is not
	// taken holds every stage.
	assign en  = !out_valid_q || m_tready;
	assign pop = en;

	// Stage 1: add, sub and logic operations, partial products, first division step.
	stage_t           st1;
	logic [DW-1:0]    sum;
	logic [DW-1:0]    dif;
	logic [2*HW-1:0]  ma_x;
	logic [2*HW-1:0]  mb_x;

	always_comb begin
		sum        = head.a + head.b;
		dif        = head.a - head.b;
		st1.valid  = head_valid;
		st1.op     = head.op;
		st1.err    = head.err;
		st1.neg_a  = head.neg_a;
		st1.neg_b  = head.neg_b;
		st1.mb     = head.mb;
		{st1.rem, st1.qd} = div_step('0, head.ma, head.mb);
		st1.res    = '0;
		case (head.op)
			OP_ADD: begin
				st1.res = sum;
				if ((head.a[DW-1] ^ sum[DW-1]) && (head.b[DW-1] ^ sum[DW-1])) begin
					st1.err = ERR_OVF;
				end
			end
			OP_SUB: begin
				st1.res = dif;
				if ((head.a[DW-1] ^ head.b[DW-1]) && (head.a[DW-1] ^ dif[DW-1])) begin
					st1.err = ERR_OVF;
				end
			end
			OP_AND:  st1.res = head.a & head.b;
			OP_OR:   st1.res = head.a | head.b;
			OP_XOR:  st1.res = head.a ^ head.b;
			default: st1.res = '0;
		endcase
		ma_x = (2*HW)'(head.ma);
		mb_x = (2*HW)'(head.mb);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_s[1] <= '0;
		end else if (en) begin
			stg_s[1] <= st1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pp_s1[0] <= ma_x[HW-1:0]    * mb_x[HW-1:0];
			pp_s1[1] <= ma_x[HW-1:0]    * mb_x[2*HW-1:HW];
			pp_s1[2] <= ma_x[2*HW-1:HW] * mb_x[HW-1:0];
			pp_s1[3] <= ma_x[2*HW-1:HW] * mb_x[2*HW-1:HW];
			prod_s2  <= PW'(pp_s1[0]) + (PW'(pp_s1[1]) << HW) + (PW'(pp_s1[2]) << HW)
				+ (PW'(pp_s1[3]) << (2*HW));
		end
	end

	// Stages 2 to DW: one division step each; stage 3 also settles the product.
	for (genvar k = 2; k <= DW; k++) begin : g_stage
		stage_t nx;
		logic [DW-1:0] lo;
		logic          pneg;
		logic          povf;

		always_comb begin
			nx = stg_s[k-1];
			{nx.rem, nx.qd} = div_step(stg_s[k-1].rem, stg_s[k-1].qd, stg_s[k-1].mb);
			lo   = prod_s2[DW-1:0];
			pneg = (stg_s[k-1].neg_a ^ stg_s[k-1].neg_b) && (prod_s2 != '0);
			povf = (prod_s2[PW-1:DW] != '0)
				|| (lo[DW-1] && !(pneg && (lo[DW-2:0] == '0)));
			if (k == 3 && stg_s[k-1].op == OP_MUL) begin
				if (povf) begin
					nx.err = ERR_OVF;
					nx.res = '0;
				end else begin
					nx.res = pneg ? (DW'(0) - lo) : lo;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				stg_s[k] <= '0;
			end else if (en) begin
				stg_s[k] <= nx;
			end
		end
	end

	// Final sign fix for quotient and remainder, zero on any error.
	logic [DW-1:0] fin;

	always_comb begin
		case (stg_s[DW].op)
			OP_DIV: fin = (stg_s[DW].neg_a ^ stg_s[DW].neg_b)
				? (DW'(0) - stg_s[DW].qd) : stg_s[DW].qd;
			OP_MOD: fin = stg_s[DW].neg_a ? (DW'(0) - stg_s[DW].rem) : stg_s[DW].rem;
			default: fin = stg_s[DW].res;
		endcase
		if (stg_s[DW].err != ERR_OK) fin = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= stg_s[DW].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_res_q <= RW'($signed(fin));
			out_err_q <= stg_s[DW].err;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_res_q;
	assign m_tuser  = out_err_q;

endmodule

// File: design/checked_int64_alu_core.sv
// Top level of the checked 64-bit signed integer ALU.
//
// Input stream: s_tdata carries the left operand in bits 63:0 and the right
// operand in bits 127:64; s_tuser carries the operation code (add, sub, mul,
// div, mod, and, or, xor). Output stream: m_tdata carries the result,
// m_tuser the error code (ok, signed overflow, zero divisor); the result is
// zero whenever an error is flagged.
// One beat may be accepted every cycle while nothing stalls. A beat passes
// through the front register, the queue and the stages of the execution
// pipeline (one restoring division step per stage, which sets the depth) and
// then sits in the output register.
// Every operation takes the same path, so results leave in input order.
// When the receiver holds m_tready low the pipeline freezes; the four-entry
// queue and the front register go on taking beats until they are full.
// Reset empties every stage and the queue; nothing is emitted until a beat
// has been accepted.
`timescale 1ns / 1ps
module checked_int64_alu_core import cia_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [2*OPW-1:0]    s_tdata,  // left_operand, right_operand
	input  logic [FUNC_W-1:0]   s_tuser,  // func
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [RW-1:0]       m_tdata,  // result_value
	output logic [ERR_W-1:0]    m_tuser   // error_code
);

	logic  push;
	item_t push_item;
	logic  push_ready;
	logic  pop;
	item_t head;
	logic  head_valid;

	cia_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.push       (push),
		.push_item  (push_item),
		.push_ready (push_ready)
	);

	cia_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	cia_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule

// File: sim/tb_top.sv
// Self-checking testbench of the checked signed integer ALU with a result scoreboard.
`timescale 1ns / 1ps
module tb_top;
	import cia_pkg::*;

	typedef struct {
		logic [63:0] value;
		err_t        err;
	} alu_result_t;

	// Predicts each result from the operands and checks beats in order.
	class alu_scoreboard;
		alu_result_t pending[$];
		int          errors;

		function alu_result_t compute(op_t op, logic [63:0] a, logic [63:0] b);
			alu_result_t r;
			logic [63:0]  minv, ma, mb, q, lo;
			logic [127:0] prod;
			logic         na, nb, neg;
			r.value = '0;
			r.err   = ERR_OK;
			minv = 64'h8000_0000_0000_0000;
			na = a[63];
			nb = b[63];
			ma = na ? -a : a;
			mb = nb ? -b : b;
			case (op)
				OP_ADD: begin
					r.value = a + b;
					if ((a[63] == b[63]) && (r.value[63] != a[63])) r.err = ERR_OVF;
				end
				OP_SUB: begin
					r.value = a - b;
					if ((a[63] != b[63]) && (r.value[63] != a[63])) r.err = ERR_OVF;
				end
				OP_MUL: begin
					prod = {64'd0, ma} * {64'd0, mb};
					lo = prod[63:0];
					neg = (na != nb) && (prod != 0);
					if (prod[127:64] != 0 || lo > (neg ? minv : minv - 1)) r.err = ERR_OVF;
					else r.value = neg ? -lo : lo;
				end
				OP_DIV, OP_MOD: begin
					if (b == 0) r.err = ERR_ZERO;
					else if (a == minv && b == '1) r.err = ERR_OVF;
					else if (op == OP_DIV) begin
						q = ma / mb;
						r.value = (na != nb) ? -q : q;
					end else begin
						q = ma % mb;
						r.value = na ? -q : q;
					end
				end
				OP_AND: r.value = a & b;
				OP_OR:  r.value = a | b;
				default: r.value = a ^ b;
			endcase
			if (r.err != ERR_OK) r.value = '0;
			return r;
		endfunction

		function void note_operands(op_t op, logic [63:0] a, logic [63:0] b);
			pending.insert(pending.size(), compute(op, a, b));
		endfunction

		function void check_result(logic [63:0] value, logic [1:0] err);
			alu_result_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result beat value=%h err=%0d", $time, value, err);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (value !== e.value) begin
				$display("%0t: result mismatch expected %h actual %h", $time, e.value, value);
				errors++;
			end
			if (err !== e.err) begin
				$display("%0t: error code mismatch expected %0d actual %0d", $time, e.err, err);
				errors++;
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;
	logic [2:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [63:0]  m_tdata;
	logic [1:0]   m_tuser;
	alu_scoreboard board;

	checked_int64_alu_core dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("** checked_int64_alu_core: FAILED **");
		$finish;
	end

	// Sends one beat after a random gap and returns at the edge that takes it.
	task automatic send_beat(op_t op, logic [63:0] a, logic [63:0] b);
		int gap;
		gap = $urandom_range(0, 3);
		@(negedge clk);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {b, a};
		do @(posedge clk); while (!s_tready);
		board.note_operands(op, a, b);
	endtask

	// Drops the valid line after the last beat of a burst.
	task automatic idle_input();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	function automatic logic [63:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return 64'h8000_0000_0000_0000;
			1: return 64'h7fff_ffff_ffff_ffff;
			2: return '1;
			3: return '0;
			4: return 64'($signed($urandom_range(0, 200)) - 100);
			5: return {{32{1'b0}}, 32'($urandom())};
			6: return {{33{$urandom_range(0, 1) == 1}}, 31'($urandom())};
			default: return {32'($urandom()), 32'($urandom())};
		endcase
	endfunction

	// Receiver side: random stalls per beat, with an unstalled stretch.
	initial begin
		int stall;
		int n;
		m_tready = 1'b0;
		n = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = (n % 200 < 50) ? 0 : $urandom_range(0, 3);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			board.check_result(m_tdata, m_tuser);
			n++;
		end
	end

	initial begin
		logic [63:0] edges[5];
		board = new();
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		arst_n   = 1'b0;
		edges = '{64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff, '1, '0, 64'd1};
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		// Directed: every operation on extremes, zero divisor, minimum by minus one.
		for (int k = 0; k < 8; k++) send_beat(op_t'(k), edges[k % 5], edges[(k + 2) % 5]);
		send_beat(OP_DIV, 64'h8000_0000_0000_0000, '1);
		send_beat(OP_MOD, 64'h8000_0000_0000_0000, '1);
		send_beat(OP_DIV, 64'd7, '0);
		send_beat(OP_MOD, 64'h8000_0000_0000_0000, '0);
		send_beat(OP_DIV, -64'sd7, 64'd2);
		send_beat(OP_MOD, -64'sd7, 64'd2);
		send_beat(OP_MUL, 64'h8000_0000_0000_0000, 64'd1);
		send_beat(OP_MUL, 64'h8000_0000_0000_0000, '1);
		send_beat(OP_MUL, 64'h0000_0001_0000_0000, 64'hffff_ffff_8000_0000);
		send_beat(OP_MUL, 64'h0000_0001_0000_0000, 64'h0000_0000_8000_0000);
		send_beat(OP_ADD, 64'h7fff_ffff_ffff_ffff, 64'd1);
		send_beat(OP_SUB, 64'h8000_0000_0000_0000, 64'd1);
		send_beat(OP_XOR, '1, 64'h5555_5555_5555_5555);
		idle_input();
		// Hold off until every result so far has come back.
		while (board.pending.size() != 0) @(negedge clk);
		for (int i = 0; i < 500; i++)
			send_beat(op_t'($urandom_range(0, 7)), pick_operand(), pick_operand());
		idle_input();
		while (board.pending.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (board.errors == 0)
			$display("** checked_int64_alu_core: PASSED **");
		else
			$display("** checked_int64_alu_core: FAILED **");
		$finish;
	end
endmodule

// File: sim.f
design/cia_pkg.sv
design/cia_front.sv
design/cia_queue.sv
design/cia_back.sv
design/checked_int64_alu_core.sv
sim/tb_top.sv
